// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files of the PID controller block.
// Included by the top level; needs clk_i and rst_ni in scope for PIDD_ASSERT.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the given active-low reset is asserted.
`define PIDD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define PIDD_ASSERT(lbl, prop, msg) `PIDD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: hw/rtl/pidd_pkg.sv
// Package of the PID controller: default sizes, mode and register codes,
// and the per-transaction control struct. No dependencies.
package pidd_pkg;

  localparam int DATA_WIDTH_DEF  = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int SUM_WIDTH_DEF   = 48;
  localparam int WRAP_ENABLE_DEF = 0;

  localparam int QUEUE_DEPTH = 4;
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);

  typedef enum logic [1:0] {
    MODE_SAMPLE  = 2'd0,
    MODE_TARGET  = 2'd1,
    MODE_RESET   = 2'd2,
    MODE_CLR_INT = 2'd3
  } mode_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_DEAD_ZONE = 3'd3,
    REG_DRIVE_MIN = 3'd4,
    REG_DRIVE_MAX = 3'd5,
    REG_SPAN_MIN  = 3'd6,
    REG_SPAN_MAX  = 3'd7
  } reg_idx_e;

  // What the back end must do with the held drive value.
  typedef struct packed {
    logic sample;     // new drive from the products
    logic clr_drive;  // drive reads zero (setpoint change or full reset)
  } item_ctl_t;

endpackage

// File: hw/rtl/pidd_if.sv
// Valid/ready channel interfaces of the PID controller: sample in, result out.
// Depends on pidd_pkg for the default data width.
interface pidd_smp_if #(
  parameter int DW = pidd_pkg::DATA_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic signed [DW-1:0] measured;
  logic signed [DW-1:0] new_target;
  logic [DW-2:0]        tolerance;

  modport source (output valid, mode, measured, new_target, tolerance, input ready);
  modport sink   (input valid, mode, measured, new_target, tolerance, output ready);
endinterface

interface pidd_res_if #(
  parameter int DW = pidd_pkg::DATA_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] drive;
  logic signed [DW-1:0] error_now;
  logic signed [DW-1:0] target_now;
  logic                 on_target;

  modport source (output valid, drive, error_now, target_now, on_target, input ready);
  modport sink   (input valid, drive, error_now, target_now, on_target, output ready);
endinterface

// File: hw/rtl/pid_controller_deadband_wrap.sv
// Top level of the PID controller with dead band and error wrap.
// Depends on pidd_pkg, pidd_if, pidd_cfg, pidd_fifo, pidd_front, pidd_back.
//
//  channel   dir  handshake          payload
//  smp_i     in   valid/ready        mode, measured, new_target, tolerance
//  res_o     out  valid/ready        drive, error_now, target_now, on_target
//  apb       in   psel/penable/...   paddr, pwdata, prdata (pready tied high)
//
// One transaction per cycle sustained while nothing stalls; a result passes the
// queue slot, product stage, partial-sum stage and result register in turn.
// The front end updates error, integral and setpoint state on the accepting
// cycle; the back end's multiply and sum stages set the latency.
// A stalled result backs up the back end, then the four-entry queue; smp_i.ready
// drops when the queue is full or a span register is written. Async reset.
`include "assert_macros.svh"

module pid_controller_deadband_wrap #(
  parameter int DATA_WIDTH  = pidd_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS   = pidd_pkg::FRAC_BITS_DEF,
  parameter int SUM_WIDTH   = pidd_pkg::SUM_WIDTH_DEF,
  parameter int WRAP_ENABLE = pidd_pkg::WRAP_ENABLE_DEF
) (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  pidd_smp_if.sink                                                smp_i,
  pidd_res_if.source                                              res_o,
  input  logic                                                    psel,
  input  logic                                                    penable,
  input  logic                                                    pwrite,
  input  logic [pidd_pkg::REG_IDX_W+((DATA_WIDTH > 32) ? 3 : 2)-1:0] paddr,
  input  logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0]                pwdata,
  output logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0]                prdata,
  output logic                                                    pready
);
  import pidd_pkg::*;

  localparam int DW     = DATA_WIDTH;
  localparam int SW     = SUM_WIDTH;
  localparam int PDATA  = (DW > 32) ? 64 : 32;
  localparam int ADDR_W = REG_IDX_W + ((DW > 32) ? 3 : 2);
  localparam int ENT_W  = 2 + DW + SW + (DW + 1) + DW + DW + 1;
  localparam int QPW    = $clog2(QUEUE_DEPTH);

  logic [NUM_REGS-1:0][DW-1:0] regs;
  logic                        span_wr;
  logic signed [DW-1:0]        span_min_nx, span_max_nx;

  logic                        smp_acc, seen;
  item_ctl_t                   f_ctl, b_ctl;
  logic signed [DW-1:0]        f_pe, f_err, f_tgt, b_pe, b_err, b_tgt;
  logic signed [SW-1:0]        f_sum, b_sum;
  logic signed [DW:0]          f_diff, b_diff;
  logic                        f_on, b_on;

  logic [ENT_W-1:0]            q_wdata, q_rdata;
  logic                        q_valid, q_full, q_pop;
  logic [QPW:0]                q_cnt;

  pidd_cfg #(
    .DW  (DW),
    .PDW (PDATA),
    .AW  (ADDR_W)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .regs_o        (regs),
    .span_wr_o     (span_wr),
    .span_min_nx_o (span_min_nx),
    .span_max_nx_o (span_max_nx)
  );

  // a span write owns the front end state for its cycle
  assign smp_i.ready = !q_full && !span_wr;
  assign smp_acc     = smp_i.valid && !q_full && !span_wr;

  pidd_front #(
    .DW   (DW),
    .SW   (SW),
    .WRAP (WRAP_ENABLE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (smp_acc),
    .mode_i       (smp_i.mode),
    .measured_i   (smp_i.measured),
    .new_target_i (smp_i.new_target),
    .tolerance_i  (smp_i.tolerance),
    .dead_zone_i  (regs[REG_DEAD_ZONE][DW-2:0]),
    .span_min_i   (span_min_nx),
    .span_max_i   (span_max_nx),
    .span_wr_i    (span_wr),
    .ctl_o        (f_ctl),
    .pe_o         (f_pe),
    .sum_o        (f_sum),
    .diff_o       (f_diff),
    .err_o        (f_err),
    .tgt_o        (f_tgt),
    .on_o         (f_on),
    .seen_o       (seen)
  );

  assign q_wdata = {f_ctl, f_pe, f_sum, f_diff, f_err, f_tgt, f_on};
  assign {b_ctl, b_pe, b_sum, b_diff, b_err, b_tgt, b_on} = q_rdata;

  pidd_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (smp_acc && !span_wr),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .valid_o (q_valid),
    .full_o  (q_full),
    .count_o (q_cnt)
  );

  pidd_back #(
    .DW (DW),
    .FB (FRAC_BITS),
    .SW (SW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_pop),
    .ctl_i       (b_ctl),
    .pe_i        (b_pe),
    .sum_i       (b_sum),
    .diff_i      (b_diff),
    .err_i       (b_err),
    .tgt_i       (b_tgt),
    .on_i        (b_on),
    .gain_p_i    ($signed(regs[REG_GAIN_P])),
    .gain_i_i    ($signed(regs[REG_GAIN_I])),
    .gain_d_i    ($signed(regs[REG_GAIN_D])),
    .drive_min_i ($signed(regs[REG_DRIVE_MIN])),
    .drive_max_i ($signed(regs[REG_DRIVE_MAX])),
    .clr_i       (span_wr),
    .res_o       (res_o)
  );

  `PIDD_ASSERT(a_queue_bound, q_cnt <= (QPW+1)'(QUEUE_DEPTH), "queue count beyond depth")
  `PIDD_ASSERT(a_sample_seen, smp_acc && smp_i.mode == MODE_SAMPLE |=> seen, "sample not recorded")
  `PIDD_ASSERT(a_reset_clears, smp_acc && smp_i.mode == MODE_RESET |=> !seen, "full reset left sample flag set")

endmodule

// File: hw/rtl/pidd_cfg.sv
// APB register file of the PID controller: gains, dead band, drive and span limits.
// Depends on pidd_pkg for register codes.
module pidd_cfg #(
  parameter int DW  = pidd_pkg::DATA_WIDTH_DEF,
  parameter int PDW = 32,
  parameter int AW  = 5
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [AW-1:0]                           paddr,
  input  logic [PDW-1:0]                          pwdata,
  output logic [PDW-1:0]                          prdata,
  output logic                                    pready,
  output logic [pidd_pkg::NUM_REGS-1:0][DW-1:0]   regs_o,
  output logic                                    span_wr_o,
  output logic signed [DW-1:0]                    span_min_nx_o,
  output logic signed [DW-1:0]                    span_max_nx_o
);
  import pidd_pkg::*;

  localparam int SL = AW - REG_IDX_W;
  localparam logic [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  logic [NUM_REGS-1:0][DW-1:0] regs_q, regs_d;
  logic [REG_IDX_W-1:0]        idx;
  logic                        wr;

  // register values after reset: widest drive limits, everything else zero
  function automatic logic [NUM_REGS-1:0][DW-1:0] regs_rst();
    logic [NUM_REGS-1:0][DW-1:0] r;
    r                = '0;
    r[REG_DRIVE_MIN] = DMIN;
    r[REG_DRIVE_MAX] = DMAX;
    return r;
  endfunction

  assign pready = 1'b1;
  assign idx    = paddr[AW-1:SL];
  assign wr     = psel && penable && pwrite;

  always_comb begin
    regs_d = regs_q;
    if (wr) begin
      if (idx == REG_DEAD_ZONE) begin
        regs_d[idx] = {1'b0, pwdata[DW-2:0]};
      end else begin
        regs_d[idx] = pwdata[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= regs_rst();
    end else begin
      regs_q <= regs_d;
    end
  end

  assign prdata        = PDW'(regs_q[idx]);
  assign regs_o        = regs_q;
  assign span_wr_o     = wr && (idx == REG_SPAN_MIN || idx == REG_SPAN_MAX);
  // values in effect after this edge, for the setpoint re-clamp
  assign span_min_nx_o = $signed(regs_d[REG_SPAN_MIN]);
  assign span_max_nx_o = $signed(regs_d[REG_SPAN_MAX]);

endmodule

// File: hw/rtl/pidd_fifo.sv
// Small transaction queue between the front and back ends of the PID controller.
// Generic width; no package dependency.
module pidd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       valid_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH):0]     count_o
);
  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PW:0]      cnt_q;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && valid_o;
  assign rdata_o = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_ok) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_ok)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_ok && !pop_ok) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/pidd_front.sv
// Front end of the PID controller: error, wrap, integral and setpoint state,
// one transaction per cycle. Depends on pidd_pkg (mode codes, control struct).
module pidd_front #(
  parameter int DW   = pidd_pkg::DATA_WIDTH_DEF,
  parameter int SW   = pidd_pkg::SUM_WIDTH_DEF,
  parameter int WRAP = pidd_pkg::WRAP_ENABLE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  acc_i,
  input  logic [1:0]            mode_i,
  input  logic signed [DW-1:0]  measured_i,
  input  logic signed [DW-1:0]  new_target_i,
  input  logic [DW-2:0]         tolerance_i,
  input  logic [DW-2:0]         dead_zone_i,
  input  logic signed [DW-1:0]  span_min_i,
  input  logic signed [DW-1:0]  span_max_i,
  input  logic                  span_wr_i,
  output pidd_pkg::item_ctl_t   ctl_o,
  output logic signed [DW-1:0]  pe_o,
  output logic signed [SW-1:0]  sum_o,
  output logic signed [DW:0]    diff_o,
  output logic signed [DW-1:0]  err_o,
  output logic signed [DW-1:0]  tgt_o,
  output logic                  on_o,
  output logic                  seen_o
);
  import pidd_pkg::*;

  localparam int SE = ((SW > DW) ? SW : DW) + 1;
  localparam logic [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  logic signed [DW-1:0] tgt_q, tgt_d, prev_q, prev_d, cur_q, cur_d, lm_q, lm_d;
  logic signed [SW-1:0] sum_q, sum_d;
  logic                 seen_q, seen_d;

  logic signed [DW:0]   err_raw, lm_dist;
  logic [DW:0]          mag_raw, mag_lm;
  logic signed [DW+1:0] err_w;
  logic signed [DW-1:0] err, tgt_new;
  logic [DW-1:0]        err_mag;
  logic signed [SE-1:0] sum_wide;
  logic signed [SW-1:0] sum_sat;

  function automatic logic signed [DW-1:0] clamp_tgt(input logic signed [DW-1:0] want,
                                                     input logic signed [DW-1:0] lo,
                                                     input logic signed [DW-1:0] hi);
    logic signed [DW-1:0] r;
    r = want;
    if (hi > lo) begin
      if (want > hi) begin
        r = hi;
      end else if (want < lo) begin
        r = lo;
      end
    end
    return r;
  endfunction

  assign err_raw = (DW+1)'(tgt_q) - (DW+1)'(measured_i);
  assign mag_raw = err_raw[DW] ? $unsigned(-err_raw) : $unsigned(err_raw);
  assign lm_dist = (DW+1)'(lm_q) - (DW+1)'(tgt_q);
  assign mag_lm  = lm_dist[DW] ? $unsigned(-lm_dist) : $unsigned(lm_dist);

  if (WRAP != 0) begin : g_wrap
    logic signed [DW:0] span;
    logic               over;
    assign span = (DW+1)'(span_max_i) - (DW+1)'(span_min_i);
    // twice the magnitude against the span; a negative span always wraps
    assign over = $signed({2'b00, mag_raw, 1'b0}) > $signed({{3{span[DW]}}, span});
    always_comb begin
      if (!over) begin
        err_w = (DW+2)'(err_raw);
      end else if (err_raw > 0) begin
        err_w = (DW+2)'(err_raw) - (DW+2)'(span);
      end else begin
        err_w = (DW+2)'(err_raw) + (DW+2)'(span);
      end
    end
  end else begin : g_nowrap
    assign err_w = (DW+2)'(err_raw);
  end

  // saturate to the data width
  assign err = (&err_w[DW+1:DW-1] || ~|err_w[DW+1:DW-1]) ? err_w[DW-1:0]
             : (err_w[DW+1] ? $signed(DMIN) : $signed(DMAX));
  assign err_mag = err[DW-1] ? $unsigned(-err) : $unsigned(err);

  assign sum_wide = SE'(sum_q) + SE'(err);
  assign sum_sat  = (&sum_wide[SE-1:SW-1] || ~|sum_wide[SE-1:SW-1]) ? sum_wide[SW-1:0]
                  : (sum_wide[SE-1] ? $signed(SMIN) : $signed(SMAX));

  assign tgt_new = clamp_tgt(new_target_i, span_min_i, span_max_i);

  always_comb begin
    tgt_d  = tgt_q;
    prev_d = prev_q;
    cur_d  = cur_q;
    lm_d   = lm_q;
    sum_d  = sum_q;
    seen_d = seen_q;

    ctl_o  = '0;
    pe_o   = err;
    sum_o  = sum_sat;
    diff_o = (DW+1)'(err) - (DW+1)'(prev_q);
    err_o  = cur_q;
    tgt_o  = tgt_q;
    on_o   = 1'b0;

    if (span_wr_i) begin
      tgt_d  = clamp_tgt(tgt_q, span_min_i, span_max_i);
      prev_d = '0;
      lm_d   = '0;
      sum_d  = '0;
      seen_d = 1'b0;
    end else if (acc_i) begin
      case (mode_e'(mode_i))
        MODE_SAMPLE: begin
          ctl_o.sample = 1'b1;
          if (err_mag < {1'b0, dead_zone_i}) pe_o = '0;
          err_o  = err;
          on_o   = (mag_raw < {2'b00, tolerance_i});
          lm_d   = measured_i;
          seen_d = 1'b1;
          cur_d  = err;
          sum_d  = sum_sat;
          prev_d = err;
        end
        MODE_TARGET: begin
          ctl_o.clr_drive = 1'b1;
          tgt_o  = tgt_new;
          tgt_d  = tgt_new;
          prev_d = '0;
          lm_d   = '0;
          sum_d  = '0;
          seen_d = 1'b0;
        end
        MODE_RESET: begin
          ctl_o.clr_drive = 1'b1;
          tgt_o  = '0;
          tgt_d  = '0;
          prev_d = '0;
          lm_d   = '0;
          sum_d  = '0;
          seen_d = 1'b0;
        end
        MODE_CLR_INT: begin
          on_o  = seen_q && (mag_lm < {2'b00, tolerance_i});
          sum_d = '0;
        end
        default: begin
          sum_d = sum_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q  <= '0;
      prev_q <= '0;
      cur_q  <= '0;
      lm_q   <= '0;
      sum_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      tgt_q  <= tgt_d;
      prev_q <= prev_d;
      cur_q  <= cur_d;
      lm_q   <= lm_d;
      sum_q  <= sum_d;
      seen_q <= seen_d;
    end
  end

  assign seen_o = seen_q;

endmodule

// File: hw/rtl/pidd_back.sv
// Back end of the PID controller: P, I, D products, sum, shift, drive clamp
// and result register. Depends on pidd_pkg (control struct) and pidd_res_if.
module pidd_back #(
  parameter int DW = pidd_pkg::DATA_WIDTH_DEF,
  parameter int FB = pidd_pkg::FRAC_BITS_DEF,
  parameter int SW = pidd_pkg::SUM_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pidd_pkg::item_ctl_t  ctl_i,
  input  logic signed [DW-1:0] pe_i,
  input  logic signed [SW-1:0] sum_i,
  input  logic signed [DW:0]   diff_i,
  input  logic signed [DW-1:0] err_i,
  input  logic signed [DW-1:0] tgt_i,
  input  logic                 on_i,
  input  logic signed [DW-1:0] gain_p_i,
  input  logic signed [DW-1:0] gain_i_i,
  input  logic signed [DW-1:0] gain_d_i,
  input  logic signed [DW-1:0] drive_min_i,
  input  logic signed [DW-1:0] drive_max_i,
  input  logic                 clr_i,
  pidd_res_if.source           res_o
);
  import pidd_pkg::*;

  localparam int LO  = SW / 2;
  localparam int HI  = SW - LO;
  localparam int PPW = 2 * DW;
  localparam int DPW = 2 * DW + 1;
  localparam int ILW = DW + LO + 1;
  localparam int IHW = DW + HI;
  localparam int IW  = DW + SW;
  localparam int PDW = 2 * DW + 2;
  localparam int TW  = ((IW > PDW) ? IW : PDW) + 1;

  // stage 1: products
  logic                  v1_q;
  item_ctl_t             ctl1_q;
  logic signed [PPW-1:0] pp_q, pp_d;
  logic signed [DPW-1:0] dp_q, dp_d;
  logic signed [ILW-1:0] ilo_q, ilo_d;
  logic signed [IHW-1:0] ihi_q, ihi_d;
  logic signed [DW-1:0]  err1_q, tgt1_q;
  logic                  on1_q;

  // stage 2: partial sums
  logic                  v2_q;
  item_ctl_t             ctl2_q;
  logic signed [IW-1:0]  isum_q, isum_d;
  logic signed [PDW-1:0] pd_q, pd_d;
  logic signed [DW-1:0]  err2_q, tgt2_q;
  logic                  on2_q;

  // stage 3: result register; drive_q also holds the last drive
  logic                  v3_q;
  logic signed [DW-1:0]  drive_q, drive_d, err3_q, tgt3_q;
  logic                  on3_q;

  logic signed [TW-1:0]  tot, sh;
  logic                  en1, en2, en3;

  assign en3        = !v3_q || res_o.ready;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  assign pp_d  = gain_p_i * pe_i;
  assign dp_d  = gain_d_i * diff_i;
  assign ilo_d = gain_i_i * $signed({1'b0, sum_i[LO-1:0]});
  assign ihi_d = gain_i_i * $signed(sum_i[SW-1:LO]);

  assign isum_d = (IW'(ihi_q) <<< LO) + IW'(ilo_q);
  assign pd_d   = PDW'(pp_q) + PDW'(dp_q);

  assign tot = TW'(isum_q) + TW'(pd_q);
  assign sh  = tot >>> FB;

  always_comb begin
    drive_d = drive_q;
    if (ctl2_q.sample) begin
      if (sh > TW'(drive_max_i)) begin
        drive_d = drive_max_i;
      end else if (sh < TW'(drive_min_i)) begin
        drive_d = drive_min_i;
      end else begin
        drive_d = sh[DW-1:0];
      end
    end else if (ctl2_q.clr_drive) begin
      drive_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ctl1_q <= ctl_i;
      pp_q   <= pp_d;
      dp_q   <= dp_d;
      ilo_q  <= ilo_d;
      ihi_q  <= ihi_d;
      err1_q <= err_i;
      tgt1_q <= tgt_i;
      on1_q  <= on_i;
    end
    if (en2) begin
      ctl2_q <= ctl1_q;
      isum_q <= isum_d;
      pd_q   <= pd_d;
      err2_q <= err1_q;
      tgt2_q <= tgt1_q;
      on2_q  <= on1_q;
    end
    if (en3 && v2_q) begin
      err3_q <= err2_q;
      tgt3_q <= tgt2_q;
      on3_q  <= on2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      drive_q <= '0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (clr_i) begin
        drive_q <= '0;
      end else if (en3 && v2_q) begin
        drive_q <= drive_d;
      end
    end
  end

  assign res_o.valid      = v3_q;
  assign res_o.drive      = drive_q;
  assign res_o.error_now  = err3_q;
  assign res_o.target_now = tgt3_q;
  assign res_o.on_target  = on3_q;

endmodule
